// ===== src/pkvh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkvh_pkg
// shared defaults and reserved label codes for the per-key label vote
// histogram
// ----------------------------------------------------------------------------
package pkvh_pkg;

    localparam int KEY_BITS_DEF   = 8;
    localparam int LABEL_BITS_DEF = 6;
    localparam int COUNT_BITS_DEF = 20;

    localparam int RSVD_NULL_LABEL = 0;
    localparam int RSVD_LOW_LABEL  = 1;

endpackage

// ===== src/per_key_label_vote_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_label_vote_histogram
// joint key and label histogram with a running majority label per key
// ----------------------------------------------------------------------------
// One pixel beat in gives one result beat out. After reset the count memory
// is swept clear, one entry a cycle, over all 2**(KEY_BITS+LABEL_BITS) entries
// (16384 with the defaults) while s_ready stays low; configuration writes
// are taken throughout. After that a pixel is taken every clock unless the
// result side stalls, and its result beat is registered through the stage-1
// registers and the result register. Each pixel does one read-modify-write
// of its count entry and its key's leader entry, read in the accept cycle
// and written back as it advances; the previous write is forwarded, so equal
// keys or labels in a row do not stall. Ties go to the smallest label, counts
// saturate, and with the filter bit set labels 0 and 1 pass through uncounted.
// ----------------------------------------------------------------------------
module per_key_label_vote_histogram #(
    parameter int KEY_BITS   = pkvh_pkg::KEY_BITS_DEF,
    parameter int LABEL_BITS = pkvh_pkg::LABEL_BITS_DEF,
    parameter int COUNT_BITS = pkvh_pkg::COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KEY_BITS-1:0]   s_pixel_key,
    input  logic [LABEL_BITS-1:0] s_pixel_label,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LABEL_BITS-1:0] m_majority_label,
    output logic [COUNT_BITS-1:0] m_majority_votes,
    output logic                  m_counted
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  filter_reg;
    logic                  clearing;
    logic                  accept;
    logic                  in_skip;
    logic                  advance;

    logic                  v1_reg;
    logic [KEY_BITS-1:0]   key1_reg;
    logic [LABEL_BITS-1:0] label1_reg;
    logic                  skip1_reg;

    logic [COUNT_BITS-1:0] rd_count;
    logic [LABEL_BITS-1:0] rd_lead_label;
    logic [COUNT_BITS-1:0] rd_lead_votes;

    logic                  fwd_valid_reg;
    logic [KEY_BITS-1:0]   fwd_key_reg;
    logic [LABEL_BITS-1:0] fwd_label_reg;
    logic [COUNT_BITS-1:0] fwd_count_reg;
    logic [LABEL_BITS-1:0] fwd_lead_label_reg;
    logic [COUNT_BITS-1:0] fwd_lead_votes_reg;

    logic [COUNT_BITS-1:0] cur_count;
    logic [LABEL_BITS-1:0] cur_lead_label;
    logic [COUNT_BITS-1:0] cur_lead_votes;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  do_write;
    logic [LABEL_BITS-1:0] lead_label_next;
    logic [COUNT_BITS-1:0] lead_votes_next;

    logic                  m_valid_reg;
    logic [LABEL_BITS-1:0] m_label_reg;
    logic [COUNT_BITS-1:0] m_votes_reg;
    logic                  m_counted_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= 1'b0;
        end else if (cfg_valid) begin
            filter_reg <= cfg_data;
        end
    end

    // handshake
    assign advance = v1_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing && (!v1_reg || advance);
    assign accept  = s_valid && s_ready;
    assign in_skip = filter_reg &&
                     (s_pixel_label == LABEL_BITS'(pkvh_pkg::RSVD_NULL_LABEL) ||
                      s_pixel_label == LABEL_BITS'(pkvh_pkg::RSVD_LOW_LABEL));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= 1'b1;
        end else if (advance) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key1_reg   <= s_pixel_key;
            label1_reg <= s_pixel_label;
            skip1_reg  <= in_skip;
        end
    end

    // read data with forwarding of the previous write
    always_comb begin
        cur_count      = rd_count;
        cur_lead_label = rd_lead_label;
        cur_lead_votes = rd_lead_votes;
        if (fwd_valid_reg && fwd_key_reg == key1_reg) begin
            cur_lead_label = fwd_lead_label_reg;
            cur_lead_votes = fwd_lead_votes_reg;
            if (fwd_label_reg == label1_reg) begin
                cur_count = fwd_count_reg;
            end
        end
    end

    // vote update
    always_comb begin
        inc_count       = cur_count + 1'b1;
        do_write        = !skip1_reg && (cur_count != COUNT_MAX);
        lead_label_next = cur_lead_label;
        lead_votes_next = cur_lead_votes;
        if (do_write) begin
            priority if (inc_count > cur_lead_votes) begin
                lead_label_next = label1_reg;
                lead_votes_next = inc_count;
            end else if (inc_count == cur_lead_votes && label1_reg < cur_lead_label) begin
                lead_label_next = label1_reg;
            end
        end
    end

    pkvh_vote_store #(
        .KEY_BITS   (KEY_BITS),
        .LABEL_BITS (LABEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clearing      (clearing),
        .rd_en         (accept),
        .rd_key        (s_pixel_key),
        .rd_label      (s_pixel_label),
        .rd_count      (rd_count),
        .rd_lead_label (rd_lead_label),
        .rd_lead_votes (rd_lead_votes),
        .wr_en         (advance && do_write),
        .wr_key        (key1_reg),
        .wr_label      (label1_reg),
        .wr_count      (inc_count),
        .wr_lead_label (lead_label_next),
        .wr_lead_votes (lead_votes_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (advance && do_write) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && do_write) begin
            fwd_key_reg        <= key1_reg;
            fwd_label_reg      <= label1_reg;
            fwd_count_reg      <= inc_count;
            fwd_lead_label_reg <= lead_label_next;
            fwd_lead_votes_reg <= lead_votes_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_label_reg   <= lead_label_next;
            m_votes_reg   <= lead_votes_next;
            m_counted_reg <= !skip1_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_majority_label = m_label_reg;
    assign m_majority_votes = m_votes_reg;
    assign m_counted        = m_counted_reg;

endmodule

// ===== src/pkvh_vote_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkvh_vote_store
// vote count memory per key and label, leader memory per key, registered
// reads, with a clearing sweep after reset
// ----------------------------------------------------------------------------
module pkvh_vote_store #(
    parameter int KEY_BITS   = pkvh_pkg::KEY_BITS_DEF,
    parameter int LABEL_BITS = pkvh_pkg::LABEL_BITS_DEF,
    parameter int COUNT_BITS = pkvh_pkg::COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clearing,
    input  logic                  rd_en,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [LABEL_BITS-1:0] rd_label,
    output logic [COUNT_BITS-1:0] rd_count,
    output logic [LABEL_BITS-1:0] rd_lead_label,
    output logic [COUNT_BITS-1:0] rd_lead_votes,
    input  logic                  wr_en,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [LABEL_BITS-1:0] wr_label,
    input  logic [COUNT_BITS-1:0] wr_count,
    input  logic [LABEL_BITS-1:0] wr_lead_label,
    input  logic [COUNT_BITS-1:0] wr_lead_votes
);

    localparam int SLOT_BITS = KEY_BITS + LABEL_BITS;
    localparam int LEAD_BITS = LABEL_BITS + COUNT_BITS;

    logic [COUNT_BITS-1:0] count_mem [2**SLOT_BITS];
    logic [LEAD_BITS-1:0]  lead_mem  [2**KEY_BITS];

    logic                  clr_active_reg;
    logic [SLOT_BITS-1:0]  clr_addr_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [LEAD_BITS-1:0]  rd_lead_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            count_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            count_mem[{wr_key, wr_label}] <= wr_count;
        end
        if (rd_en) begin
            rd_count_reg <= count_mem[{rd_key, rd_label}];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            lead_mem[clr_addr_reg[SLOT_BITS-1:LABEL_BITS]] <= '0;
        end else if (wr_en) begin
            lead_mem[wr_key] <= {wr_lead_label, wr_lead_votes};
        end
        if (rd_en) begin
            rd_lead_reg <= lead_mem[rd_key];
        end
    end

    assign clearing      = clr_active_reg;
    assign rd_count      = rd_count_reg;
    assign rd_lead_label = rd_lead_reg[LEAD_BITS-1:COUNT_BITS];
    assign rd_lead_votes = rd_lead_reg[COUNT_BITS-1:0];

endmodule

// ===== tb/sv/per_key_label_vote_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_label_vote_histogram_tb
// self-checking bench for the per-key label vote histogram
// ----------------------------------------------------------------------------
// Pixel beats go in through the s_ channel. Each accepted beat is run through
// a behavioural copy of the count store and the per-key leaders, which queues
// the expected majority label, vote count and counted flag. Each result beat
// is checked against the oldest queued entry. Directed beats cover the
// reserved-label filter, ties on increment, field extremes and a full-rate
// run on one key. Random phases then alternate the filter setting,
// with hot keys and labels to build up counts and ties, while the sender
// idles in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module per_key_label_vote_histogram_tb;

    localparam int KEY_BITS   = pkvh_pkg::KEY_BITS_DEF;
    localparam int LABEL_BITS = pkvh_pkg::LABEL_BITS_DEF;
    localparam int COUNT_BITS = pkvh_pkg::COUNT_BITS_DEF;
    localparam int NUM_KEYS   = 1 << KEY_BITS;
    localparam int NUM_LABELS = 1 << LABEL_BITS;
    localparam bit [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [COUNT_BITS-1:0] votes;
        logic                  counted;
    } vote_result_t;

    class vote_scoreboard;
        bit [COUNT_BITS-1:0] tally [NUM_KEYS*NUM_LABELS];
        bit [LABEL_BITS-1:0] lead_label [NUM_KEYS];
        bit [COUNT_BITS-1:0] lead_votes [NUM_KEYS];
        bit                  filter_on;
        vote_result_t        pending [$];
        int                  errors;

        function void note_pixel(input bit [KEY_BITS-1:0] key,
                                 input bit [LABEL_BITS-1:0] lbl);
            vote_result_t                   want;
            bit [COUNT_BITS-1:0]            c;
            bit [KEY_BITS+LABEL_BITS-1:0]   slot;
            bit                             skip;
            skip = filter_on && (lbl == pkvh_pkg::RSVD_NULL_LABEL ||
                                 lbl == pkvh_pkg::RSVD_LOW_LABEL);
            if (!skip) begin
                slot = {key, lbl};
                c = tally[slot];
                if (c != COUNT_MAX) begin
                    c = c + 1'b1;
                    tally[slot] = c;
                    if (c > lead_votes[key]) begin
                        lead_votes[key] = c;
                        lead_label[key] = lbl;
                    end else if (c == lead_votes[key] && lbl < lead_label[key]) begin
                        lead_label[key] = lbl;
                    end
                end
            end
            want.label   = lead_label[key];
            want.votes   = lead_votes[key];
            want.counted = !skip;
            pending.insert(pending.size(), want);
        endfunction

        function void check_result(input logic [LABEL_BITS-1:0] lbl,
                                   input logic [COUNT_BITS-1:0] votes,
                                   input logic counted);
            vote_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, label %0d votes %0d counted %0d",
                         $time, lbl, votes, counted);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (lbl !== want.label) begin
                $display("%0t: majority_label expected %0d actual %0d",
                         $time, want.label, lbl);
                errors++;
            end
            if (votes !== want.votes) begin
                $display("%0t: majority_votes expected %0d actual %0d",
                         $time, want.votes, votes);
                errors++;
            end
            if (counted !== want.counted) begin
                $display("%0t: counted expected %0d actual %0d",
                         $time, want.counted, counted);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data      = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [KEY_BITS-1:0]   s_pixel_key   = '0;
    logic [LABEL_BITS-1:0] s_pixel_label = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [LABEL_BITS-1:0] m_majority_label;
    logic [COUNT_BITS-1:0] m_majority_votes;
    logic                  m_counted;

    vote_scoreboard sb;

    int          tx_gap_max  = 6;
    int          tx_burst    = 4;
    bit          rx_free     = 1'b0;
    bit [15:0]   rx_pattern  = 16'hffff;
    int unsigned rx_phase    = 0;

    per_key_label_vote_histogram #(
        .KEY_BITS   (KEY_BITS),
        .LABEL_BITS (LABEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel_key      (s_pixel_key),
        .s_pixel_label    (s_pixel_label),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_majority_label (m_majority_label),
        .m_majority_votes (m_majority_votes),
        .m_counted        (m_counted)
    );

    always #5 aclk = ~aclk;

    // receiver stalls on a 16-bit rotating word, renewed whenever the low byte of the phase wraps to zero
    always @(posedge aclk) begin
        rx_phase = rx_phase + 1;
        if (rx_phase[7:0] == 8'd0) begin
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                     : (16'($urandom()) | 16'h0001);
        end
        m_ready <= rx_free ? 1'b1 : rx_pattern[rx_phase[3:0]];
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_majority_label, m_majority_votes, m_counted);
            end
            if (s_valid && s_ready) begin
                sb.note_pixel(s_pixel_key, s_pixel_label);
            end
        end
    end

    task automatic write_filter(input bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.filter_on = value;
    endtask

    task automatic send_pixel(input logic [KEY_BITS-1:0] key,
                              input logic [LABEL_BITS-1:0] lbl);
        s_valid       <= 1'b1;
        s_pixel_key   <= key;
        s_pixel_label <= lbl;
        do @(posedge aclk); while (!s_ready);
        if (tx_gap_max > 0) begin
            if (tx_burst == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge aclk);
                tx_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 10);
            end else begin
                tx_burst--;
            end
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int n_items);
        logic [KEY_BITS-1:0]   hot_key [4];
        logic [LABEL_BITS-1:0] hot_label [4];
        logic [KEY_BITS-1:0]   key;
        logic [LABEL_BITS-1:0] lbl;
        for (int j = 0; j < 4; j++) begin
            hot_key[j]   = KEY_BITS'($urandom_range(0, NUM_KEYS - 1));
            hot_label[j] = $urandom_range(0, 1) ? LABEL_BITS'($urandom_range(0, 3))
                                    : LABEL_BITS'($urandom_range(0, NUM_LABELS - 1));
        end
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                key = hot_key[$urandom_range(0, 3)];
                lbl = hot_label[$urandom_range(0, 3)];
            end else begin
                key = KEY_BITS'($urandom_range(0, NUM_KEYS - 1));
                lbl = LABEL_BITS'($urandom_range(0, NUM_LABELS - 1));
            end
            send_pixel(key, lbl);
        end
        drain();
    endtask

    initial begin
        int sat_len;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // filter on: reserved labels pass through uncounted
        write_filter(1'b1);
        send_pixel(8'd0, 6'd0);
        send_pixel(8'd0, 6'd1);
        send_pixel(8'd0, 6'd2);
        send_pixel(8'd0, 6'd0);
        send_pixel(8'd255, 6'd63);
        send_pixel(8'd255, 6'd1);
        drain();

        // filter off: ties on increment and field extremes
        write_filter(1'b0);
        send_pixel(8'd0, 6'd0);
        send_pixel(8'd0, 6'd1);
        send_pixel(8'd3, 6'd9);
        send_pixel(8'd3, 6'd4);
        send_pixel(8'd3, 6'd9);
        send_pixel(8'd3, 6'd4);
        send_pixel(8'd3, 6'd63);
        send_pixel(8'd255, 6'd0);
        send_pixel(8'd128, 6'd32);
        send_pixel(8'd127, 6'd31);
        send_pixel(8'd85, 6'd21);
        send_pixel(8'd170, 6'd42);
        drain();

        // one key hammered at full rate, then a rival label
        tx_gap_max = 0;
        rx_free    = 1'b1;
        sat_len    = 40;
        for (int i = 0; i < sat_len; i++) begin
            send_pixel(8'd200, 6'd17);
        end
        send_pixel(8'd200, 6'd3);
        send_pixel(8'd200, 6'd17);
        drain();
        tx_gap_max = 6;
        rx_free    = 1'b0;

        run_random(450);
        write_filter(1'b1);
        run_random(450);
        write_filter(1'b0);
        run_random(450);
        write_filter(1'b1);
        run_random(450);

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("per_key_label_vote_histogram_tb: done, clean");
        end else begin
            $display("per_key_label_vote_histogram_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("per_key_label_vote_histogram_tb: done, errors");
        $finish;
    end

endmodule
